// ===== src/ccsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccsm_pkg
// shared types and constants of the sparse-dense product engine
// ----------------------------------------------------------------------------
package ccsm_pkg;

  localparam int unsigned DimMax   = 64;
  localparam int unsigned NzDepth  = 1024;
  localparam int unsigned ColDepth = 64;
  localparam int unsigned DnDepth  = 4096;

  localparam logic [1:0] RegSparseRows = 2'd0;
  localparam logic [1:0] RegSparseCols = 2'd1;
  localparam logic [1:0] RegDenseOther = 2'd2;
  localparam logic [1:0] RegMode       = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD_SPARSE = 2'd0,
    OP_LOAD_DENSE  = 2'd1,
    OP_PRODUCT     = 2'd2,
    OP_NONE        = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    op_e                op;
    logic               reject;
    logic               mode;
    logic signed [31:0] value;
    logic [5:0]         row;
    logic [5:0]         col;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [5:0]         row;
  } nz_t;

  function automatic logic [6:0] clamp_dim(input logic [6:0] v);
    logic [6:0] r;
    if (v == 7'd0) begin
      r = 7'd1;
    end else if (v > 7'(DimMax)) begin
      r = 7'(DimMax);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== src/ccs_sparse_dense_multiply_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_sparse_dense_multiply_top
// sparse (compressed column) times dense product element engine
// ----------------------------------------------------------------------------
// A product beat first fetches the column pointers (states S_END and S_START),
// then walks one stored nonzero per cycle over the span of the column's pointers
// (at most 64 for a column loaded once since the last new matrix, up to 1024
// through stale pointers), then drains the multiply pipeline and registers the
// result; an empty column skips the walk. The nonzero store and the dense store
// are each read through one port into a single multiply pipeline. A two-entry
// command queue holds up to two further input beats while a result waits to be
// popped. No clearing pass is needed after reset.
module ccs_sparse_dense_multiply_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] value_i,
  input  logic [5:0]         row_index_i,
  input  logic [5:0]         col_index_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] product_o,
  output logic [1:0]         status_o,
  output logic               saturated_o,
  output logic [10:0]        nonzero_count_o
);

  ccsm_pkg::cmd_t f_cmd, q_cmd;
  logic           q_full, q_push, q_valid, q_pop;

  ccsm_front u_front (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .full, .operation_i, .value_i, .row_index_i, .col_index_i,
    .q_full_i (q_full),
    .q_push_o (q_push),
    .cmd_o    (f_cmd)
  );

  ccsm_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .cmd_i   (f_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  ccsm_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .pop, .empty, .product_o, .status_o, .saturated_o, .nonzero_count_o
  );

endmodule

// ===== src/ccsm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccsm_front
// configuration registers and item classification with range checks
// ----------------------------------------------------------------------------
module ccsm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          operation_i,
  input  logic signed [31:0]  value_i,
  input  logic [5:0]          row_index_i,
  input  logic [5:0]          col_index_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output ccsm_pkg::cmd_t      cmd_o
);

  logic [6:0] rows_q, cols_q, other_q;
  logic       mode_q;
  logic       wr_en;
  logic [6:0] nr, nc, nd, r7, c7;
  logic       ok;
  ccsm_pkg::op_e op;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= 7'(ccsm_pkg::DimMax);
      cols_q  <= 7'(ccsm_pkg::DimMax);
      other_q <= 7'(ccsm_pkg::DimMax);
      mode_q  <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        ccsm_pkg::RegSparseRows: rows_q  <= pwdata[6:0];
        ccsm_pkg::RegSparseCols: cols_q  <= pwdata[6:0];
        ccsm_pkg::RegDenseOther: other_q <= pwdata[6:0];
        ccsm_pkg::RegMode:       mode_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ccsm_pkg::RegSparseRows: prdata = {25'd0, rows_q};
      ccsm_pkg::RegSparseCols: prdata = {25'd0, cols_q};
      ccsm_pkg::RegDenseOther: prdata = {25'd0, other_q};
      ccsm_pkg::RegMode:       prdata = {31'd0, mode_q};
      default:                 prdata = '0;
    endcase
  end

  assign nr = ccsm_pkg::clamp_dim(rows_q);
  assign nc = ccsm_pkg::clamp_dim(cols_q);
  assign nd = ccsm_pkg::clamp_dim(other_q);
  assign r7 = {1'b0, row_index_i};
  assign c7 = {1'b0, col_index_i};
  assign op = ccsm_pkg::op_e'(operation_i);

  always_comb begin
    unique case (op)
      ccsm_pkg::OP_LOAD_SPARSE: ok = (r7 < nr) && (c7 < nc);
      ccsm_pkg::OP_LOAD_DENSE:
        ok = mode_q ? ((r7 < nd) && (c7 < nr)) : ((r7 < nr) && (c7 < nd));
      ccsm_pkg::OP_PRODUCT:
        ok = mode_q ? ((r7 < nd) && (c7 < nc)) : ((r7 < nc) && (c7 < nd));
      default: ok = 1'b1;
    endcase
  end

  assign full     = q_full_i;
  assign q_push_o = push & ~q_full_i;

  always_comb begin
    cmd_o.op     = op;
    cmd_o.reject = ~ok;
    cmd_o.mode   = mode_q;
    cmd_o.value  = value_i;
    cmd_o.row    = row_index_i;
    cmd_o.col    = col_index_i;
  end

endmodule

// ===== src/ccsm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccsm_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module ccsm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ccsm_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ccsm_pkg::cmd_t cmd_o
);

  ccsm_pkg::cmd_t entry_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  logic           do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = entry_q[rptr_q];
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(do_pop);
    end
  end

endmodule

// ===== src/ccsm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccsm_back
// stores, nonzero walk with multiply-accumulate, and the result register
// ----------------------------------------------------------------------------
module ccsm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  ccsm_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  input  logic                pop,
  output logic                empty,
  output logic signed [31:0]  product_o,
  output logic [1:0]          status_o,
  output logic                saturated_o,
  output logic [10:0]         nonzero_count_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_END   = 4'b0010,
    S_START = 4'b0100,
    S_WALK  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [10:0]     cs_mem [ccsm_pkg::ColDepth];
  ccsm_pkg::nz_t   nz_mem [ccsm_pkg::NzDepth];
  logic [31:0]     dn_mem [ccsm_pkg::DnDepth];

  logic [63:0]     cs_valid_q;
  logic            start0_q;
  logic [10:0]     cnt_q;
  ccsm_pkg::cmd_t  cmd_q;
  logic [10:0]     end_q, k_q, lim_q;

  logic [5:0]      cs_raddr;
  logic [10:0]     cs_rd_q;
  ccsm_pkg::nz_t   nz_rd_q;
  logic [31:0]     dn_rd_q;
  logic [11:0]     dn_raddr;

  logic            s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic signed [31:0] a2_q;
  logic signed [63:0] prod_q, rnd;
  logic signed [47:0] term_q;
  logic signed [63:0] acc_q;

  logic            out_v_q;
  logic signed [31:0] out_prod_q;
  logic [1:0]      out_stat_q;
  logic            out_sat_q;
  logic [10:0]     out_cnt_q;

  logic            take, is_prod, new_m, nz_wr, cs_wr, drop, issue, drained;
  logic [10:0]     base, cnt_next, start_v, end_v, end_m1;
  logic [5:0]      col_sel;

  function automatic logic [5:0] cmd_q_col_m1(input ccsm_pkg::cmd_t c);
    logic [5:0] v;
    v = c.mode ? c.col : c.row;
    return v - 6'd1;
  endfunction

  assign take    = (state_q == S_IDLE) && cmd_valid_i && !out_v_q;
  assign cmd_pop_o = take;
  assign is_prod = (cmd_i.op == ccsm_pkg::OP_PRODUCT) && !cmd_i.reject;
  assign col_sel = cmd_i.mode ? cmd_i.col : cmd_i.row;

  assign new_m    = (cmd_i.row == 6'd0) && (cmd_i.col == 6'd0);
  assign base     = new_m ? 11'd0 : cnt_q;
  assign cs_wr    = take && (cmd_i.op == ccsm_pkg::OP_LOAD_SPARSE) && !cmd_i.reject;
  assign drop     = (cmd_i.value != 32'sd0) && (base >= 11'(ccsm_pkg::NzDepth));
  assign nz_wr    = cs_wr && (cmd_i.value != 32'sd0) && !drop;
  assign cnt_next = nz_wr ? base + 11'd1 : base;

  // column pointer store, entry c holds the start of column c+1
  assign cs_raddr = (state_q == S_IDLE) ? col_sel : cmd_q_col_m1(cmd_q);

  always_ff @(posedge clk_i) begin
    if (cs_wr) begin
      cs_mem[cmd_i.col] <= cnt_next + 11'd1;
    end
    cs_rd_q <= cs_mem[cs_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (nz_wr) begin
      nz_mem[base[9:0]] <= '{value: cmd_i.value, row: cmd_i.row};
    end
    nz_rd_q <= nz_mem[k_q[9:0]];
  end

  assign dn_raddr = cmd_q.mode ? {cmd_q.row, nz_rd_q.row} : {nz_rd_q.row, cmd_q.col};

  always_ff @(posedge clk_i) begin
    if (take && (cmd_i.op == ccsm_pkg::OP_LOAD_DENSE) && !cmd_i.reject) begin
      dn_mem[{cmd_i.row, cmd_i.col}] <= cmd_i.value;
    end
    dn_rd_q <= dn_mem[dn_raddr];
  end

  logic [5:0] colq;
  assign colq   = cmd_q.mode ? cmd_q.col : cmd_q.row;
  assign end_v  = cs_valid_q[colq] ? cs_rd_q : 11'd0;
  assign start_v = (colq == 6'd0) ? {10'd0, start0_q}
                 : (cs_valid_q[colq - 6'd1] ? cs_rd_q : 11'd0);
  assign end_m1 = end_q - 11'd1;
  assign issue  = (state_q == S_WALK) && (k_q < lim_q);
  assign drained = !issue && !s1_v_q && !s2_v_q && !s3_v_q && !s4_v_q;
  assign rnd    = prod_q + 64'sd32768;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (take && is_prod) state_d = S_END;
      S_END:   state_d = S_START;
      S_START: state_d = S_WALK;
      S_WALK:  if (drained) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_i;
    end
    if (state_q == S_END) begin
      end_q <= end_v;
    end
    if (state_q == S_START) begin
      if ((start_v != 11'd0) && (end_q > start_v)) begin
        k_q   <= start_v - 11'd1;
        lim_q <= (end_m1 < cnt_q) ? end_m1 : cnt_q;
      end else begin
        k_q   <= 11'd0;
        lim_q <= 11'd0;
      end
    end else if (issue) begin
      k_q <= k_q + 11'd1;
    end
    a2_q   <= nz_rd_q.value;
    prod_q <= a2_q * $signed(dn_rd_q);
    term_q <= rnd[63:16];
    if (state_q == S_START) begin
      acc_q <= '0;
    end else if (s4_v_q) begin
      acc_q <= acc_q + 64'(term_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cs_valid_q <= '0;
      start0_q   <= 1'b0;
      cnt_q      <= '0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      s3_v_q     <= 1'b0;
      s4_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      s1_v_q  <= issue;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      if (cs_wr) begin
        cnt_q <= cnt_next;
        if (new_m) begin
          start0_q   <= 1'b1;
          cs_valid_q <= 64'd1 << cmd_i.col;
        end else begin
          cs_valid_q[cmd_i.col] <= 1'b1;
        end
      end
      if (pop && out_v_q) begin
        out_v_q <= 1'b0;
      end
      if (take && !is_prod) begin
        out_v_q <= 1'b1;
      end
      if ((state_q == S_WALK) && drained) begin
        out_v_q <= 1'b1;
      end
    end
  end

  logic ovf;
  assign ovf = !((&acc_q[63:31]) || !(|acc_q[63:31]));

  always_ff @(posedge clk_i) begin
    if (take && !is_prod) begin
      out_prod_q <= '0;
      out_sat_q  <= 1'b0;
      out_cnt_q  <= cs_wr ? cnt_next : cnt_q;
      if (cmd_i.reject && (cmd_i.op != ccsm_pkg::OP_NONE)) begin
        out_stat_q <= ccsm_pkg::ST_RANGE;
      end else if (cs_wr && drop) begin
        out_stat_q <= ccsm_pkg::ST_FULL;
      end else begin
        out_stat_q <= ccsm_pkg::ST_OK;
      end
    end else if ((state_q == S_WALK) && drained) begin
      out_prod_q <= ovf ? (acc_q[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : acc_q[31:0];
      out_sat_q  <= ovf;
      out_cnt_q  <= cnt_q;
      out_stat_q <= ccsm_pkg::ST_OK;
    end
  end

  assign empty           = ~out_v_q;
  assign product_o       = out_prod_q;
  assign status_o        = out_stat_q;
  assign saturated_o     = out_sat_q;
  assign nonzero_count_o = out_cnt_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 11'(ccsm_pkg::NzDepth))
    else $error("nonzero count past store depth");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !pop |=> out_v_q && $stable(out_prod_q))
    else $error("result beat lost before pop");

  a_pipe_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_v_q |-> state_q == S_WALK)
    else $error("accumulate outside column walk");

endmodule
